>>> sv/tet_pkg.sv
// Shared types, command and result codes for the timed event table.
package tet_pkg;

	localparam int NUM_SLOTS_DEF = 16;
	localparam int TIME_W = 63;
	localparam int DLY_W = 40;

	localparam logic [2:0] CMD_ADD      = 3'd0;
	localparam logic [2:0] CMD_SET      = 3'd1;
	localparam logic [2:0] CMD_DEL_OWN  = 3'd2;
	localparam logic [2:0] CMD_DEL_SLOT = 3'd3;
	localparam logic [2:0] CMD_ADVANCE  = 3'd4;

	localparam logic [1:0] KIND_ACK  = 2'd0;
	localparam logic [1:0] KIND_FIRE = 2'd1;
	localparam logic [1:0] KIND_FULL = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	// One incoming request.
	typedef struct packed {
		logic [2:0]       command;
		logic [3:0]       slot;
		logic [15:0]      owner;
		logic [7:0]       handler;
		logic [31:0]      arg;
		logic             repeat_req;
		logic [DLY_W-1:0] delay_ns;
		logic [DLY_W-1:0] elapsed_ns;
	} req_t;

	// One result item.
	typedef struct packed {
		logic [1:0]        kind;
		logic [3:0]        slot;
		logic [15:0]       owner;
		logic [7:0]        handler;
		logic [31:0]       arg;
		logic [DLY_W-1:0]  consumed;
		logic [TIME_W-1:0] now;
		logic              last;
	} res_t;

	// One table entry as kept in the slot memory.
	typedef struct packed {
		logic [15:0]       owner;
		logic [7:0]        handler;
		logic [31:0]       arg;
		logic [TIME_W-1:0] deadline;
		logic [DLY_W-1:0]  period;
	} entry_t;

	// Builds a result; the current time is filled in at the output.
	function automatic res_t mk_res(logic [1:0] kind, logic [3:0] slot, logic [15:0] owner,
		logic [7:0] handler, logic [31:0] arg, logic [DLY_W-1:0] consumed, logic last);
		res_t r;
		r.kind = kind;
		r.slot = slot;
		r.owner = owner;
		r.handler = handler;
		r.arg = arg;
		r.consumed = consumed;
		r.now = '0;
		r.last = last;
		return r;
	endfunction

endpackage

>>> sv/timed_event_table.sv
// Top level of the timed event table: request ports, sequencer and output register.
// Add scans for a free slot, then writes it; set writes the slot; delete slot and unknown
// commands answer without a table walk; delete by owner reads and checks every slot first.
// Advance: minimum scan over all slots, one time step, then expiry scan from the last slot,
// with a reload of each fired periodic slot; the block takes one request at a time.
// Reset clears the valid bits and the time base; slot contents are not cleared.
module timed_event_table #(
	parameter int NUM_SLOTS = tet_pkg::NUM_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [2:0]                       command,
	input  logic [3:0]                       slot,
	input  logic [15:0]                      owner,
	input  logic [7:0]                       handler,
	input  logic signed [31:0]               arg,
	input  logic                             repeat_req,
	input  logic [tet_pkg::DLY_W-1:0]        delay_ns,
	input  logic [tet_pkg::DLY_W-1:0]        elapsed_ns,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic [1:0]                       kind,
	output logic [3:0]                       slot_res,
	output logic [15:0]                      owner_out,
	output logic [7:0]                       handler_out,
	output logic signed [31:0]               arg_out,
	output logic [tet_pkg::DLY_W-1:0]        consumed_ns,
	output logic [tet_pkg::TIME_W-1:0]       now_ns,
	output logic                             last
);
	import tet_pkg::*;

	req_t req;
	res_t core_res;
	logic core_valid;
	logic core_ready;
	res_t obuf_q;
	logic obuf_valid_q;

	// Gather the request fields.
	always_comb begin
		req.command = command;
		req.slot = slot;
		req.owner = owner;
		req.handler = handler;
		req.arg = arg;
		req.repeat_req = repeat_req;
		req.delay_ns = delay_ns;
		req.elapsed_ns = elapsed_ns;
	end

	tet_core #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (core_valid),
		.res_ready (core_ready),
		.res       (core_res)
	);

	// Output register; it takes a new result when empty or being drained.
	assign core_ready = !obuf_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obuf_valid_q <= 1'b0;
		end else if (core_ready) begin
			obuf_valid_q <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ready && core_valid) begin
			obuf_q <= core_res;
		end
	end

	assign rsp_valid = obuf_valid_q;
	assign kind = obuf_q.kind;
	assign slot_res = obuf_q.slot;
	assign owner_out = obuf_q.owner;
	assign handler_out = obuf_q.handler;
	assign arg_out = obuf_q.arg;
	assign consumed_ns = obuf_q.consumed;
	assign now_ns = obuf_q.now;
	assign last = obuf_q.last;

endmodule

>>> sv/tet_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/tet_alu.sv
// Shared 63-bit adder and subtractor for deadlines and the time base.
module tet_alu (
	input  logic [tet_pkg::TIME_W-1:0] a,
	input  logic [tet_pkg::TIME_W-1:0] b,
	input  logic                       sub,
	output logic [tet_pkg::TIME_W-1:0] y
);
	import tet_pkg::*;

	// Two's complement subtract by inverting b and adding one; wraps modulo 2^63.
	assign y = a + (sub ? ~b : b) + TIME_W'(sub);

endmodule

>>> sv/tet_core.sv
// Sequencer that walks the slot table for add, delete-by-owner and advance commands.
module tet_core #(
	parameter int NUM_SLOTS = tet_pkg::NUM_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  tet_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_ready,
	output tet_pkg::res_t res
);
	import tet_pkg::*;

	localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

	typedef enum logic [10:0] {
		S_IDLE    = 11'b00000000001,
		S_FIND    = 11'b00000000010,
		S_WRITE   = 11'b00000000100,
		S_SCAN_RD = 11'b00000001000,
		S_OWN_EV  = 11'b00000010000,
		S_MIN_EV  = 11'b00000100000,
		S_TIME    = 11'b00001000000,
		S_FIRE_RD = 11'b00010000000,
		S_FIRE_EV = 11'b00100000000,
		S_RELOAD  = 11'b01000000000,
		S_RESP    = 11'b10000000000
	} state_t;

	state_t            state_q;
	logic [IW-1:0]     idx_q;
	logic [IW-1:0]     tgt_q;
	logic [2:0]        cmd_q;
	logic [15:0]       own_q;
	logic [7:0]        hnd_q;
	logic [31:0]       arg_q;
	logic              rep_q;
	logic [DLY_W-1:0]  dly_q;
	logic [DLY_W-1:0]  step_q;
	logic [TIME_W-1:0] now_q;
	logic [NUM_SLOTS-1:0] valid_q;
	res_t              res_q;

	logic [TIME_W-1:0] alu_a;
	logic [TIME_W-1:0] alu_b;
	logic              alu_sub;
	logic [TIME_W-1:0] alu_y;
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	entry_t            ram_wdata;
	logic              ram_re;
	entry_t            rd;
	logic [TIME_W-1:0] left;
	logic              expired;
	logic [DLY_W-1:0]  stp;
	logic              slot_ok;

	// Operand selection for the shared adder.
	always_comb begin
		alu_a = now_q;
		alu_b = '0;
		alu_sub = 1'b0;
		unique case (state_q)
			S_WRITE: begin
				alu_b = TIME_W'(dly_q);
			end
			S_MIN_EV, S_FIRE_EV: begin
				alu_a = rd.deadline;
				alu_b = now_q;
				alu_sub = 1'b1;
			end
			S_TIME: begin
				alu_b = TIME_W'(stp);
			end
			S_RELOAD: begin
				alu_a = rd.deadline;
				alu_b = TIME_W'(rd.period);
			end
			default: begin
				alu_b = '0;
			end
		endcase
	end

	tet_alu u_alu (
		.a   (alu_a),
		.b   (alu_b),
		.sub (alu_sub),
		.y   (alu_y)
	);

	// Remaining time of the slot being examined; a negative distance counts as reached.
	assign left = alu_y[TIME_W-1] ? '0 : alu_y;
	assign expired = valid_q[idx_q] && (left == '0);
	assign stp = (step_q == '0) ? DLY_W'(1) : step_q;
	assign slot_ok = (32'(req.slot) < NUM_SLOTS);

	// Memory write: a new entry, or a reloaded deadline.
	always_comb begin
		ram_we = (state_q == S_WRITE) || (state_q == S_RELOAD);
		ram_waddr = (state_q == S_WRITE) ? tgt_q : idx_q;
		if (state_q == S_WRITE) begin
			ram_wdata.owner = own_q;
			ram_wdata.handler = hnd_q;
			ram_wdata.arg = arg_q;
			ram_wdata.deadline = alu_y;
			ram_wdata.period = rep_q ? dly_q : '0;
		end else begin
			ram_wdata = rd;
			ram_wdata.deadline = alu_y;
		end
	end

	assign ram_re = (state_q == S_SCAN_RD) || (state_q == S_FIRE_RD);

	tet_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (NUM_SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (rd)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			now_q <= '0;
			idx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q <= req.command;
						own_q <= req.owner;
						hnd_q <= req.handler;
						arg_q <= req.arg;
						rep_q <= req.repeat_req;
						dly_q <= req.delay_ns;
						idx_q <= '0;
						unique case (req.command)
							CMD_ADD: begin
								state_q <= S_FIND;
							end
							CMD_SET: begin
								if (slot_ok) begin
									tgt_q <= IW'(req.slot);
									state_q <= S_WRITE;
								end else begin
									res_q <= mk_res(KIND_ACK, req.slot, '0, '0, '0, '0, 1'b1);
									state_q <= S_RESP;
								end
							end
							CMD_DEL_OWN: begin
								state_q <= S_SCAN_RD;
							end
							CMD_DEL_SLOT: begin
								if (slot_ok) begin
									valid_q[IW'(req.slot)] <= 1'b0;
								end
								res_q <= mk_res(KIND_ACK, req.slot, '0, '0, '0, '0, 1'b1);
								state_q <= S_RESP;
							end
							CMD_ADVANCE: begin
								if (req.elapsed_ns == '0) begin
									res_q <= mk_res(KIND_DONE, '0, '0, '0, '0, '0, 1'b1);
									state_q <= S_RESP;
								end else begin
									step_q <= req.elapsed_ns;
									state_q <= S_SCAN_RD;
								end
							end
							default: begin
								res_q <= mk_res(KIND_ACK, '0, '0, '0, '0, '0, 1'b1);
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_FIND: begin
					if (!valid_q[idx_q]) begin
						tgt_q <= idx_q;
						state_q <= S_WRITE;
					end else if (idx_q == LAST_IDX) begin
						res_q <= mk_res(KIND_FULL, '0, '0, '0, '0, '0, 1'b1);
						state_q <= S_RESP;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_WRITE: begin
					valid_q[tgt_q] <= 1'b1;
					res_q <= mk_res(KIND_ACK, 4'(tgt_q), '0, '0, '0, '0, 1'b1);
					state_q <= S_RESP;
				end
				S_SCAN_RD: begin
					state_q <= (cmd_q == CMD_ADVANCE) ? S_MIN_EV : S_OWN_EV;
				end
				S_OWN_EV: begin
					if (valid_q[idx_q] && (rd.owner == own_q)) begin
						valid_q[idx_q] <= 1'b0;
					end
					if (idx_q == LAST_IDX) begin
						res_q <= mk_res(KIND_ACK, '0, '0, '0, '0, '0, 1'b1);
						state_q <= S_RESP;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_MIN_EV: begin
					if (valid_q[idx_q] && (left < TIME_W'(step_q))) begin
						step_q <= left[DLY_W-1:0];
					end
					if (idx_q == LAST_IDX) begin
						state_q <= S_TIME;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_TIME: begin
					step_q <= stp;
					now_q <= alu_y;
					idx_q <= LAST_IDX;
					state_q <= S_FIRE_RD;
				end
				S_FIRE_RD: begin
					state_q <= S_FIRE_EV;
				end
				S_FIRE_EV: begin
					if (expired) begin
						res_q <= mk_res(KIND_FIRE, 4'(idx_q), rd.owner, rd.handler, rd.arg,
							'0, 1'b0);
						if (rd.period != '0) begin
							state_q <= S_RELOAD;
						end else begin
							valid_q[idx_q] <= 1'b0;
							state_q <= S_RESP;
						end
					end else if (idx_q == '0) begin
						res_q <= mk_res(KIND_DONE, '0, '0, '0, '0, step_q, 1'b1);
						state_q <= S_RESP;
					end else begin
						idx_q <= idx_q - 1'b1;
						state_q <= S_FIRE_RD;
					end
				end
				S_RELOAD: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						if (res_q.last) begin
							state_q <= S_IDLE;
						end else if (idx_q == '0) begin
							res_q <= mk_res(KIND_DONE, '0, '0, '0, '0, step_q, 1'b1);
						end else begin
							idx_q <= idx_q - 1'b1;
							state_q <= S_FIRE_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESP);

	// The result carries the time base as it stands after the step.
	always_comb begin
		res = res_q;
		res.now = now_q;
	end

`ifndef ASSERT_OFF
	a_now_moves_only_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_TIME) |=> $stable(now_q))
		else $error("time base changed outside the step state");

	a_step_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TIME) |=> (step_q != '0))
		else $error("advance step is zero");

	a_reload_has_period: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RELOAD) |-> (rd.period != '0))
		else $error("reload of a one-shot slot");

	a_fire_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res_q.kind == KIND_FIRE)) |-> !res_q.last)
		else $error("fired event marked as final result");
`endif

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the timed event table: directed and random requests.
`timescale 1ns / 1ps

module tb_top;
	import tet_pkg::*;

	localparam int NSLOT = NUM_SLOTS_DEF;
	localparam int LIMIT = 2000000;
	localparam logic [TIME_W-1:0] BIT62 = 63'h4000000000000000;

	// Expected results and a shadow copy of the event table.
	class event_scoreboard;
		res_t pending[$];
		int errors;
		bit used[NSLOT];
		logic [15:0] own[NSLOT];
		logic [7:0] hnd[NSLOT];
		logic [31:0] argv[NSLOT];
		logic [TIME_W-1:0] due[NSLOT];
		logic [DLY_W-1:0] period[NSLOT];
		logic [TIME_W-1:0] clock_ns;

		function new();
			errors = 0;
			clock_ns = '0;
			foreach (used[i]) used[i] = 0;
		endfunction

		function void push(logic [1:0] k, logic [3:0] s, logic [15:0] o, logic [7:0] h,
			logic [31:0] a, logic [DLY_W-1:0] c);
			res_t r;
			r.kind = k; r.slot = s; r.owner = o; r.handler = h; r.arg = a;
			r.consumed = c; r.now = clock_ns; r.last = 0;
			pending.push_back(r);
		endfunction

		function logic [TIME_W-1:0] remaining(int i);
			logic [TIME_W-1:0] d;
			d = due[i] - clock_ns;
			return (d & BIT62) ? '0 : d;
		endfunction

		function void store(int i, req_t q);
			used[i] = 1;
			own[i] = q.owner; hnd[i] = q.handler; argv[i] = q.arg;
			due[i] = clock_ns + q.delay_ns;
			period[i] = q.repeat_req ? q.delay_ns : '0;
		endfunction

		// Works out every result caused by one accepted request.
		function void note_request(req_t q);
			int i;
			logic [TIME_W-1:0] stepv, t;
			i = 0;
			case (q.command)
				CMD_ADD: begin
					while (i < NSLOT && used[i]) i++;
					if (i >= NSLOT) push(KIND_FULL, 0, 0, 0, 0, 0);
					else begin
						store(i, q);
						push(KIND_ACK, i[3:0], 0, 0, 0, 0);
					end
				end
				CMD_SET: begin
					if (q.slot < NSLOT) store(q.slot, q);
					push(KIND_ACK, q.slot, 0, 0, 0, 0);
				end
				CMD_DEL_OWN: begin
					for (i = 0; i < NSLOT; i++)
						if (used[i] && own[i] == q.owner) used[i] = 0;
					push(KIND_ACK, 0, 0, 0, 0, 0);
				end
				CMD_DEL_SLOT: begin
					if (q.slot < NSLOT) used[q.slot] = 0;
					push(KIND_ACK, q.slot, 0, 0, 0, 0);
				end
				CMD_ADVANCE: begin
					stepv = '0;
					if (q.elapsed_ns != 0) begin
						stepv = q.elapsed_ns;
						for (i = 0; i < NSLOT; i++)
							if (used[i]) begin
								t = remaining(i);
								if (t < stepv) stepv = t;
							end
						if (stepv < 1) stepv = 1;
						clock_ns = clock_ns + stepv;
						for (i = NSLOT - 1; i >= 0; i--)
							if (used[i] && remaining(i) == 0) begin
								if (period[i] != 0) due[i] = due[i] + period[i];
								else used[i] = 0;
								push(KIND_FIRE, i[3:0], own[i], hnd[i], argv[i], 0);
							end
					end
					push(KIND_DONE, 0, 0, 0, 0, stepv[DLY_W-1:0]);
				end
				default: push(KIND_ACK, 0, 0, 0, 0, 0);
			endcase
			pending[$].last = 1;
		endfunction

		// Compares one accepted result with the oldest expectation.
		function void check_result(res_t got);
			res_t e;
			if (pending.size() == 0) begin
				$error("result with nothing expected: kind %0d", got.kind);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.kind !== e.kind) begin
				$error("kind exp %0d got %0d", e.kind, got.kind); errors++; end
			if (got.slot !== e.slot) begin
				$error("slot_res exp %0d got %0d", e.slot, got.slot); errors++; end
			if (got.owner !== e.owner) begin
				$error("owner_out exp %h got %h", e.owner, got.owner); errors++; end
			if (got.handler !== e.handler) begin
				$error("handler_out exp %h got %h", e.handler, got.handler); errors++; end
			if (got.arg !== e.arg) begin
				$error("arg_out exp %h got %h", e.arg, got.arg); errors++; end
			if (got.consumed !== e.consumed) begin
				$error("consumed_ns exp %0d got %0d", e.consumed, got.consumed); errors++; end
			if (got.now !== e.now) begin
				$error("now_ns exp %0d got %0d", e.now, got.now); errors++; end
			if (got.last !== e.last) begin
				$error("last exp %0d got %0d", e.last, got.last); errors++; end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0, req_ready, rsp_valid, rsp_ready = 0;
	logic [2:0] command = '0;
	logic [3:0] slot = '0;
	logic [15:0] owner = '0;
	logic [7:0] handler = '0;
	logic signed [31:0] arg = '0;
	logic repeat_req = 0;
	logic [DLY_W-1:0] delay_ns = '0, elapsed_ns = '0;
	logic [1:0] kind;
	logic [3:0] slot_res;
	logic [15:0] owner_out;
	logic [7:0] handler_out;
	logic signed [31:0] arg_out;
	logic [DLY_W-1:0] consumed_ns;
	logic [TIME_W-1:0] now_ns;
	logic last;

	event_scoreboard sb = new();
	int cycles = 0;

	timed_event_table u_dut (.*);

	always #5 clk = ~clk;

	// Cycle limit on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Offers one request and waits for it to be taken; valid stays up when no gap follows.
	task automatic send_request(req_t q);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			req_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1;
		command <= q.command; slot <= q.slot; owner <= q.owner; handler <= q.handler;
		arg <= q.arg; repeat_req <= q.repeat_req;
		delay_ns <= q.delay_ns; elapsed_ns <= q.elapsed_ns;
		do @(posedge clk); while (!req_ready);
		sb.note_request(q);
	endtask

	function automatic logic [DLY_W-1:0] rand_time();
		case ($urandom_range(0, 4))
			0: return DLY_W'($urandom_range(1, 20));
			1: return DLY_W'($urandom_range(1, 2000));
			2: return DLY_W'({$urandom, $urandom});
			3: return {DLY_W{1'b1}};
			default: return DLY_W'($urandom_range(0, 300));
		endcase
	endfunction

	function automatic req_t rand_request();
		req_t q;
		int p;
		q.slot = 4'($urandom_range(0, 15));
		q.owner = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3));
		q.handler = 8'($urandom);
		q.arg = $urandom;
		q.repeat_req = 1'($urandom_range(0, 1));
		q.delay_ns = rand_time();
		q.elapsed_ns = rand_time();
		p = $urandom_range(0, 99);
		if (p < 30) q.command = CMD_ADD;
		else if (p < 40) q.command = CMD_SET;
		else if (p < 46) q.command = CMD_DEL_OWN;
		else if (p < 54) q.command = CMD_DEL_SLOT;
		else if (p < 97) q.command = CMD_ADVANCE;
		else q.command = 3'($urandom_range(5, 7));
		return q;
	endfunction

	// Response side: random stalls, with one long hold-off to back the block up.
	initial begin
		res_t r;
		int stall, n;
		n = 0;
		@(posedge arst_n);
		forever begin
			if (n == 40) stall = 400;
			else stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				rsp_ready <= 0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1;
			do @(posedge clk); while (!rsp_valid);
			r.kind = kind; r.slot = slot_res; r.owner = owner_out; r.handler = handler_out;
			r.arg = arg_out; r.consumed = consumed_ns; r.now = now_ns; r.last = last;
			sb.check_result(r);
			n++;
		end
	end

	// Directed requests, then random ones, then drain and report.
	initial begin
		req_t q;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		q = '0;
		// Advance on an empty table, with zero and full requested time.
		q.command = CMD_ADVANCE; q.elapsed_ns = 0; send_request(q);
		q.elapsed_ns = {DLY_W{1'b1}}; send_request(q);
		// Fill the table, then one add past full.
		for (int i = 0; i < NSLOT + 1; i++) begin
			q = '0;
			q.command = CMD_ADD;
			q.owner = i[0] ? 16'hFFFF : 16'h0000;
			q.handler = i[0] ? 8'hFF : 8'h00;
			q.arg = i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			q.repeat_req = i[1];
			q.delay_ns = (i == 3) ? {DLY_W{1'b1}} : DLY_W'(i + 1);
			send_request(q);
		end
		// Overwrite a used slot, drop one, drop an owner, unknown command.
		q.command = CMD_SET; q.slot = 4'hF; q.delay_ns = 5; q.repeat_req = 1; send_request(q);
		q.command = CMD_DEL_SLOT; q.slot = 4'h2; send_request(q);
		q.command = CMD_DEL_OWN; q.owner = 16'hFFFF; send_request(q);
		q.command = 3'd7; send_request(q);
		// Advances: one that stops at the earliest deadline and fires it, then a short one.
		q.command = CMD_ADVANCE; q.elapsed_ns = 100; send_request(q);
		q.elapsed_ns = 3; send_request(q);

		for (int n = 0; n < 500; n++) send_request(rand_request());
		// A last advance with full requested time before the drain.
		q = '0; q.command = CMD_ADVANCE; q.elapsed_ns = {DLY_W{1'b1}}; send_request(q);
		req_valid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
